[rtl/core/array_list_keyed_remove_macros.svh]
// Assertion macros for the keyed array list.
`ifndef ARRAY_LIST_KEYED_REMOVE_MACROS_SVH
`define ARRAY_LIST_KEYED_REMOVE_MACROS_SVH

// Check on every clock edge, reset included.
`define ALKR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check on clock edges outside of reset.
`define ALKR_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[rtl/core/alkr_pkg.sv]
`timescale 1ns / 1ps

package alkr_pkg;

   localparam int CAPACITY_DEFAULT = 64;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

endpackage

[rtl/core/array_list_keyed_remove.sv]
`timescale 1ns / 1ps
// Append and unused codes go from acceptance straight to S_FINISH, which registers rsp_valid.
// Search and remove scan from the top entry down, one memory read per cycle; remove then
// shifts every later entry down by one position in S_SHIFT.
// One transaction at a time: req_ready returns as the result is registered in S_FINISH.
// Reset is synchronous and clears the count and control state; entries are not cleared.

module array_list_keyed_remove #(
   parameter int CAPACITY = alkr_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [alkr_pkg::OP_W-1:0]          req_operation,
   input  logic signed [alkr_pkg::KEY_W-1:0]  req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [alkr_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_found,
   output logic [alkr_pkg::POS_W-1:0]         rsp_position,
   output logic [alkr_pkg::COUNT_W-1:0]       rsp_count,
   output logic                               rsp_is_full,
   output logic                               rsp_is_empty
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CX = CW + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [alkr_pkg::KEY_W-1:0]      key_ff, key_in;
   logic                            remove_ff, remove_in;
   logic [IW-1:0]                   scan_ff, scan_in;
   logic [alkr_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                            res_found_ff, res_found_in;
   logic [IW-1:0]                   res_pos_ff, res_pos_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [alkr_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [alkr_pkg::POS_W-1:0]      rsp_position_ff, rsp_position_in;
   logic [alkr_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                            rsp_is_full_ff, rsp_is_full_in;
   logic                            rsp_is_empty_ff, rsp_is_empty_in;

   logic                            mem_we;
   logic [IW-1:0]                   mem_waddr;
   logic [alkr_pkg::KEY_W-1:0]      mem_wdata;
   logic [IW-1:0]                   mem_raddr;
   logic [alkr_pkg::KEY_W-1:0]      mem_rdata;

   logic [CX-1:0]                   scan_ext;
   logic [CX-1:0]                   count_ext;

   alkr_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (alkr_pkg::KEY_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign scan_ext  = CX'(scan_ff);
   assign count_ext = CX'(count_ff);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      key_in          = key_ff;
      remove_in       = remove_ff;
      scan_in         = scan_ff;
      res_status_in   = res_status_ff;
      res_found_in    = res_found_ff;
      res_pos_in      = res_pos_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_is_full_in  = rsp_is_full_ff;
      rsp_is_empty_in = rsp_is_empty_ff;
      mem_we          = 1'b0;
      mem_waddr       = count_ff[IW-1:0];
      mem_wdata       = req_key;
      mem_raddr       = scan_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in        = req_key;
               remove_in     = (req_operation == alkr_pkg::OP_REMOVE);
               res_status_in = alkr_pkg::ST_DONE;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               state_in      = S_FINISH;
               case (req_operation)
                  alkr_pkg::OP_APPEND: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        res_status_in = alkr_pkg::ST_FULL;
                     end else begin
                        mem_we       = 1'b1;
                        res_found_in = 1'b1;
                        res_pos_in   = count_ff[IW-1:0];
                        count_in     = count_ff + CW'(1);
                     end
                  end
                  alkr_pkg::OP_SEARCH, alkr_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = alkr_pkg::ST_ABSENT;
                     end else begin
                        mem_raddr = IW'(count_ff - CW'(1));
                        scan_in   = IW'(count_ff - CW'(1));
                        state_in  = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (mem_rdata == key_ff) begin
               res_status_in = alkr_pkg::ST_DONE;
               res_found_in  = 1'b1;
               res_pos_in    = scan_ff;
               state_in      = S_FINISH;
               if (remove_ff) begin
                  if (scan_ext + CX'(1) < count_ext) begin
                     mem_raddr = IW'(scan_ext + CX'(1));
                     state_in  = S_SHIFT;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
            end else if (scan_ff == '0) begin
               res_status_in = alkr_pkg::ST_ABSENT;
               res_found_in  = 1'b0;
               res_pos_in    = '0;
               state_in      = S_FINISH;
            end else begin
               mem_raddr = scan_ff - IW'(1);
               scan_in   = scan_ff - IW'(1);
            end
         end
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = mem_rdata;
            if (scan_ext + CX'(2) < count_ext) begin
               mem_raddr = IW'(scan_ext + CX'(2));
               scan_in   = scan_ff + IW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_found_in    = res_found_ff;
               rsp_position_in = alkr_pkg::POS_W'(res_pos_ff);
               rsp_count_in    = alkr_pkg::COUNT_W'(count_ff);
               rsp_is_full_in  = (count_ff == CW'(CAPACITY));
               rsp_is_empty_in = (count_ff == '0);
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff          <= key_in;
      remove_ff       <= remove_in;
      scan_ff         <= scan_in;
      res_status_ff   <= res_status_in;
      res_found_ff    <= res_found_in;
      res_pos_ff      <= res_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_is_full_ff  <= rsp_is_full_in;
      rsp_is_empty_ff <= rsp_is_empty_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_full  = rsp_is_full_ff;
   assign rsp_is_empty = rsp_is_empty_ff;

endmodule

[rtl/core/alkr_mem.sv]
`timescale 1ns / 1ps

module alkr_mem #(
   parameter int DEPTH = alkr_pkg::CAPACITY_DEFAULT,
   parameter int WIDTH = alkr_pkg::KEY_W
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/alkr_checker.sv]
`timescale 1ns / 1ps
`include "array_list_keyed_remove_macros.svh"

module alkr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [alkr_pkg::OP_W-1:0]          req_operation,
   input logic signed [alkr_pkg::KEY_W-1:0]  req_key,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [alkr_pkg::STATUS_W-1:0]      rsp_status,
   input logic                               rsp_found,
   input logic [alkr_pkg::POS_W-1:0]         rsp_position,
   input logic [alkr_pkg::COUNT_W-1:0]       rsp_count,
   input logic                               rsp_is_full,
   input logic                               rsp_is_empty
);

   `ALKR_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "rsp_valid after reset")
   `ALKR_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_count), "stalled transaction changed")
   `ALKR_ASSERT_RUN(a_found_done, clock, reset, rsp_valid && rsp_found |-> rsp_status == alkr_pkg::ST_DONE, "found with failing status")
   `ALKR_ASSERT_RUN(a_miss_pos, clock, reset, rsp_valid && !rsp_found |-> rsp_position == '0, "position set without a hit")
   `ALKR_ASSERT_RUN(a_empty_flag, clock, reset, rsp_valid |-> (rsp_is_empty == (rsp_count == '0)) && !(rsp_is_empty && rsp_is_full), "empty flag disagrees with count")

endmodule

bind array_list_keyed_remove alkr_checker u_alkr_checker (.*);
